// ===== rtl/swet_pkg.sv =====
// ----------------------------------------------------------------------------
// swet_pkg
// shared types and constants of the sliding window event trigger
// ----------------------------------------------------------------------------
package swet_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned ST_W     = 4;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CFG_AW   = 3;
    localparam int unsigned OUT_IW   = 24;

    // register indexes of the configuration port
    localparam logic [CFG_AW-1:0] REG_WINDOW_DURATION = 3'd0;
    localparam logic [CFG_AW-1:0] REG_PRE_DELTA       = 3'd1;
    localparam logic [CFG_AW-1:0] REG_POST_DELTA      = 3'd2;
    localparam logic [CFG_AW-1:0] REG_DEAD_TIME       = 3'd3;
    localparam logic [CFG_AW-1:0] REG_MIN_STATIONS    = 3'd4;
    localparam logic [CFG_AW-1:0] REG_MIN_HITS        = 3'd5;

    typedef enum logic [1:0] {
        MODE_SEARCH  = 2'd0,
        MODE_COLLECT = 2'd1,
        MODE_DEAD    = 2'd2
    } mode_t;

    typedef enum logic [15:0] {
        S_IDLE   = 16'h0001,
        S_MODE   = 16'h0002,
        S_CAP_RD = 16'h0004,
        S_CAP_RM = 16'h0008,
        S_CAP_ST = 16'h0010,
        S_WRITE  = 16'h0020,
        S_ADD_WR = 16'h0040,
        S_CHK    = 16'h0080,
        S_EV_RD  = 16'h0100,
        S_EV_CMP = 16'h0200,
        S_EV_WR  = 16'h0400,
        S_TRIG   = 16'h0800,
        S_LB_RD  = 16'h1000,
        S_LB_CMP = 16'h2000,
        S_LAST   = 16'h4000,
        S_OUT    = 16'h8000
    } state_t;

    // one entry of the hit ring
    typedef struct packed {
        logic [ST_W-1:0]   station;
        logic [TIME_W-1:0] hit_time;
    } ring_entry_t;

    // exact signed difference of two tick counts
    function automatic logic signed [TIME_W:0] tdiff(input logic [TIME_W-1:0] a,
                                                      input logic [TIME_W-1:0] b);
        return $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

endpackage

// ===== rtl/sliding_window_event_trigger_core.sv =====
// ----------------------------------------------------------------------------
// sliding_window_event_trigger_core
// multiplicity trigger over a sliding time window of detector hits
// ----------------------------------------------------------------------------
// Hits enter one at a time on the s_ channel, time ordered within a slice,
// with tlast on the final hit of a slice. All hit times and stations are kept
// in a single-port ring memory of RING_DEPTH entries; per-station counts live
// in a small synchronous memory with one valid bit per entry, so a window
// clear resets the valid bits instead of the counts. Each hit is processed by a sequencer that reads,
// modifies and writes these memories one access at a time. While searching,
// a hit steps through the mode check, the ring write, the count update (left
// out when its station is out of range), the window check and the trigger
// check; while collecting or in dead time it goes through the mode check and
// the ring write only. A full window in search first drops its oldest hit.
// When the newest hit lies outside the window, an age-out walk removes the
// hits that leave it, oldest first, and after a trigger the look-back walks
// over at most RING_DEPTH hits. One hit is worked on at a time; a finished
// event waits in the output register and does not hold off the next hit
// until a second event is ready. Events leave on the m_ channel as first and
// last slice index, with the clamp flag in tuser.
// The ring holds no reset: entries are only read after they were written.
// ----------------------------------------------------------------------------
module sliding_window_event_trigger_core #(
    parameter int unsigned RING_DEPTH   = 4096,
    parameter int unsigned NUM_STATIONS = 16,
    parameter int unsigned INDEX_BITS   = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_wr_en,
    input  logic [swet_pkg::CFG_AW-1:0]   cfg_index,
    input  logic [swet_pkg::CFG_W-1:0]    cfg_wdata,
    // hit input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [39:0]                   s_tdata,   // hit_time[31:0], station[35:32]
    input  logic                          s_tlast,   // slice_last
    // event output
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [47:0]                   m_tdata,   // first_index[23:0], last_index[47:24]
    output logic                          m_tuser    // lookback_clamped
);
    import swet_pkg::*;

    localparam int unsigned RA      = $clog2(RING_DEPTH);
    localparam int unsigned SA      = (NUM_STATIONS > 1) ? $clog2(NUM_STATIONS) : 1;
    localparam int unsigned SHW     = $clog2(NUM_STATIONS + 1);
    localparam int unsigned WIN_CAP = (RING_DEPTH < 65535) ? RING_DEPTH : 65535;
    localparam int unsigned CW      = 16;

    // ring pointer helpers, depth need not be a power of two
    function automatic logic [RA-1:0] ring_sub(input logic [RA-1:0] p,
                                               input logic [CW-1:0] n);
        logic [RA:0] s;
        s = {1'b0, p} + (RA+1)'(RING_DEPTH) - (RA+1)'(n);
        if (s >= (RA+1)'(RING_DEPTH)) begin
            s = s - (RA+1)'(RING_DEPTH);
        end
        return s[RA-1:0];
    endfunction

    function automatic logic [RA-1:0] ring_inc(input logic [RA-1:0] p);
        return (p == RA'(RING_DEPTH - 1)) ? '0 : p + RA'(1);
    endfunction

    function automatic logic [RA-1:0] ring_dec(input logic [RA-1:0] p);
        return (p == '0) ? RA'(RING_DEPTH - 1) : p - RA'(1);
    endfunction

    function automatic logic st_ok(input logic [ST_W-1:0] s);
        return 32'(s) < NUM_STATIONS;
    endfunction

    // configuration registers
    logic [15:0] win_dur_reg, pre_reg, post_reg, dead_reg, min_hits_reg;
    logic [4:0]  min_st_reg;

    // sequencer and window state
    state_t              state_reg, state_next;
    mode_t               mode_reg, mode_next;
    logic [RA-1:0]       wp_reg, wp_next;
    logic [CW-1:0]       wh_reg, wh_next;
    logic [SHW-1:0]      sh_reg, sh_next;
    logic [INDEX_BITS-1:0] wsi_reg, wsi_next;
    logic [TIME_W-1:0]   wst_reg, wst_next;
    logic                empty_reg, empty_next;
    logic [INDEX_BITS-1:0] hidx_reg, hidx_next;
    logic [TIME_W-1:0]   trig_reg, trig_next;
    logic [INDEX_BITS-1:0] evf_reg, evf_next;
    logic                evc_reg, evc_next;

    // current hit
    logic [TIME_W-1:0]   t_reg, t_next;
    logic [ST_W-1:0]     st_reg, st_next;
    logic                last_reg, last_next;
    logic [INDEX_BITS-1:0] i_reg, i_next;

    // event waiting for the output register
    logic                pend_reg, pend_next;
    logic [INDEX_BITS-1:0] pf_reg, pf_next, pl_reg, pl_next;
    logic                pc_reg, pc_next;

    // look-back walk
    logic [RA:0]         k_reg, k_next;
    logic [RA-1:0]       lbp_reg, lbp_next;
    logic                rem_reg, rem_next;

    // output register
    logic                mv_reg, mv_next;
    logic [INDEX_BITS-1:0] mf_reg, mf_next, ml_reg, ml_next;
    logic                mc_reg, mc_next;

    // hit ring memory
    ring_entry_t         ring_mem [RING_DEPTH];
    ring_entry_t         ring_q, ring_wdata;
    logic                ring_we, ring_re;
    logic [RA-1:0]       ring_raddr;

    // station count memory with valid bits
    logic [CW-1:0]       cnt_mem [NUM_STATIONS];
    logic [CW-1:0]       cnt_q, cnt_wdata, cnt_cur;
    logic                cnt_we, cnt_re;
    logic [SA-1:0]       cnt_raddr, cnt_waddr;
    logic [SA-1:0]       ca_reg, ca_next;
    logic [NUM_STATIONS-1:0] cv_reg, cv_next;

    assign cnt_cur  = cv_reg[ca_reg] ? cnt_q : '0;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = {OUT_IW'(ml_reg), OUT_IW'(mf_reg)};
    assign m_tuser  = mc_reg;

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[wp_reg] <= ring_wdata;
        end
        if (ring_re) begin
            ring_q <= ring_mem[ring_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re) begin
            cnt_q <= cnt_mem[cnt_raddr];
        end
    end

    always_comb begin
        mode_t                 m;
        logic                  clr;
        logic                  emit;
        logic                  lb_done;
        logic                  lb_brk;
        logic signed [TIME_W:0] d;
        logic [INDEX_BITS-1:0] ef, el;
        logic                  ec;

        state_next = state_reg;
        mode_next  = mode_reg;
        wp_next    = wp_reg;
        wh_next    = wh_reg;
        sh_next    = sh_reg;
        wsi_next   = wsi_reg;
        wst_next   = wst_reg;
        empty_next = empty_reg;
        hidx_next  = hidx_reg;
        trig_next  = trig_reg;
        evf_next   = evf_reg;
        evc_next   = evc_reg;
        t_next     = t_reg;
        st_next    = st_reg;
        last_next  = last_reg;
        i_next     = i_reg;
        pend_next  = pend_reg;
        pf_next    = pf_reg;
        pl_next    = pl_reg;
        pc_next    = pc_reg;
        k_next     = k_reg;
        lbp_next   = lbp_reg;
        rem_next   = rem_reg;
        ca_next    = ca_reg;
        cv_next    = cv_reg;
        mv_next    = mv_reg && !m_tready;
        mf_next    = mf_reg;
        ml_next    = ml_reg;
        mc_next    = mc_reg;

        ring_we    = 1'b0;
        ring_re    = 1'b0;
        ring_raddr = wp_reg;
        ring_wdata = '{station: st_reg, hit_time: t_reg};
        cnt_we     = 1'b0;
        cnt_re     = 1'b0;
        cnt_raddr  = SA'(st_reg);
        cnt_waddr  = ca_reg;
        cnt_wdata  = cnt_cur;

        m       = mode_reg;
        clr     = 1'b0;
        emit    = 1'b0;
        lb_done = 1'b0;
        lb_brk  = 1'b0;
        d       = tdiff(t_reg, trig_reg);
        ef      = pf_reg;
        el      = pl_reg;
        ec      = pc_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    t_next     = s_tdata[TIME_W-1:0];
                    st_next    = s_tdata[TIME_W +: ST_W];
                    last_next  = s_tlast;
                    i_next     = hidx_reg;
                    pend_next  = 1'b0;
                    state_next = S_MODE;
                end
            end
            // close a collected event and leave dead time on the hit's time
            S_MODE: begin
                case (mode_reg)
                    MODE_SEARCH: m = MODE_SEARCH;
                    MODE_COLLECT, MODE_DEAD: begin
                        if (mode_reg == MODE_COLLECT &&
                            d > $signed({17'b0, post_reg})) begin
                            pend_next = 1'b1;
                            pf_next   = evf_reg;
                            pl_next   = i_reg - INDEX_BITS'(1);
                            pc_next   = evc_reg;
                            m         = MODE_DEAD;
                        end
                        if (m == MODE_DEAD &&
                            d > $signed({16'b0, {1'b0, post_reg} + {1'b0, dead_reg}})) begin
                            clr = 1'b1;
                            m   = MODE_SEARCH;
                        end
                    end
                    default: m = MODE_SEARCH;
                endcase
                mode_next = m;
                if (m == MODE_SEARCH && !clr && 32'(wh_reg) >= WIN_CAP) begin
                    state_next = S_CAP_RD;
                end else begin
                    state_next = S_WRITE;
                end
            end
            // full window: drop the oldest hit before the write
            S_CAP_RD: begin
                ring_re    = 1'b1;
                ring_raddr = ring_sub(wp_reg, wh_reg);
                state_next = S_CAP_RM;
            end
            S_CAP_RM: begin
                rem_next = st_ok(ring_q.station);
                if (st_ok(ring_q.station)) begin
                    cnt_re    = 1'b1;
                    cnt_raddr = SA'(ring_q.station);
                    ca_next   = SA'(ring_q.station);
                end
                ring_re    = 1'b1;
                ring_raddr = ring_sub(wp_reg, wh_reg - CW'(1));
                state_next = S_CAP_ST;
            end
            S_CAP_ST: begin
                if (rem_reg && cnt_cur != '0) begin
                    cnt_we    = 1'b1;
                    cnt_wdata = cnt_cur - CW'(1);
                    cv_next[ca_reg] = 1'b1;
                    if (cnt_cur == CW'(1) && sh_reg != '0) begin
                        sh_next = sh_reg - SHW'(1);
                    end
                end
                wh_next    = wh_reg - CW'(1);
                wsi_next   = wsi_reg + INDEX_BITS'(1);
                wst_next   = ring_q.hit_time;
                state_next = S_WRITE;
            end
            S_WRITE: begin
                ring_we = 1'b1;
                wp_next = ring_inc(wp_reg);
                if (mode_reg == MODE_SEARCH) begin
                    wh_next = wh_reg + CW'(1);
                    if (empty_reg) begin
                        wsi_next   = i_reg;
                        wst_next   = t_reg;
                        empty_next = 1'b0;
                    end
                    if (st_ok(st_reg)) begin
                        cnt_re     = 1'b1;
                        ca_next    = SA'(st_reg);
                        state_next = S_ADD_WR;
                    end else begin
                        state_next = S_CHK;
                    end
                end else begin
                    state_next = S_LAST;
                end
            end
            S_ADD_WR: begin
                cnt_we    = 1'b1;
                cnt_wdata = cnt_cur + CW'(1);
                cv_next[ca_reg] = 1'b1;
                if (cnt_cur == '0) begin
                    sh_next = sh_reg + SHW'(1);
                end
                state_next = S_CHK;
            end
            S_CHK: begin
                if (tdiff(t_reg, wst_reg) > $signed({17'b0, win_dur_reg})) begin
                    state_next = S_EV_RD;
                end else begin
                    state_next = S_TRIG;
                end
            end
            // age hits out of the window, oldest first
            S_EV_RD: begin
                if (wh_reg > CW'(1)) begin
                    ring_re    = 1'b1;
                    ring_raddr = ring_sub(wp_reg, wh_reg);
                    state_next = S_EV_CMP;
                end else begin
                    wsi_next   = i_reg;
                    wst_next   = t_reg;
                    state_next = S_TRIG;
                end
            end
            S_EV_CMP: begin
                wst_next = ring_q.hit_time;
                if (tdiff(t_reg, ring_q.hit_time) <= $signed({17'b0, win_dur_reg})) begin
                    wsi_next   = i_reg - INDEX_BITS'(wh_reg) + INDEX_BITS'(1);
                    state_next = S_TRIG;
                end else if (st_ok(ring_q.station)) begin
                    cnt_re     = 1'b1;
                    cnt_raddr  = SA'(ring_q.station);
                    ca_next    = SA'(ring_q.station);
                    state_next = S_EV_WR;
                end else begin
                    wh_next    = wh_reg - CW'(1);
                    state_next = S_EV_RD;
                end
            end
            S_EV_WR: begin
                if (cnt_cur != '0) begin
                    cnt_we    = 1'b1;
                    cnt_wdata = cnt_cur - CW'(1);
                    cv_next[ca_reg] = 1'b1;
                    if (cnt_cur == CW'(1) && sh_reg != '0) begin
                        sh_next = sh_reg - SHW'(1);
                    end
                end
                wh_next    = wh_reg - CW'(1);
                state_next = S_EV_RD;
            end
            S_TRIG: begin
                if (wh_reg >= min_hits_reg && 8'(sh_reg) >= 8'(min_st_reg)) begin
                    k_next     = '0;
                    lbp_next   = ring_dec(wp_reg);
                    state_next = S_LB_RD;
                end else begin
                    state_next = S_LAST;
                end
            end
            // look-back from the newest hit
            S_LB_RD: begin
                if (33'(k_reg) <= 33'(i_reg) && 33'(k_reg) < 33'(RING_DEPTH)) begin
                    ring_re    = 1'b1;
                    ring_raddr = lbp_reg;
                    state_next = S_LB_CMP;
                end else begin
                    lb_done = 1'b1;
                end
            end
            S_LB_CMP: begin
                if (tdiff(wst_reg, ring_q.hit_time) > $signed({17'b0, pre_reg})) begin
                    lb_done = 1'b1;
                    lb_brk  = 1'b1;
                end else begin
                    k_next     = k_reg + (RA+1)'(1);
                    lbp_next   = ring_dec(lbp_reg);
                    state_next = S_LB_RD;
                end
            end
            S_LAST: begin
                if (last_reg) begin
                    if (mode_reg == MODE_COLLECT && !pend_reg) begin
                        ef = evf_reg;
                        el = i_reg;
                        ec = evc_reg;
                        pend_next = 1'b1;
                        pf_next   = evf_reg;
                        pl_next   = i_reg;
                        pc_next   = evc_reg;
                    end
                    emit      = pend_reg || mode_reg == MODE_COLLECT;
                    clr       = 1'b1;
                    hidx_next = '0;
                    mode_next = MODE_SEARCH;
                end else begin
                    emit      = pend_reg;
                    hidx_next = i_reg + INDEX_BITS'(1);
                end
                if (!emit) begin
                    state_next = S_IDLE;
                end else if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    mf_next    = ef;
                    ml_next    = el;
                    mc_next    = ec;
                    state_next = S_IDLE;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    mf_next    = pf_reg;
                    ml_next    = pl_reg;
                    mc_next    = pc_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (lb_done) begin
            evf_next   = i_reg - INDEX_BITS'(k_reg) + INDEX_BITS'(1);
            evc_next   = !lb_brk && (33'(i_reg) >= 33'(RING_DEPTH));
            trig_next  = t_reg;
            mode_next  = MODE_COLLECT;
            state_next = S_LAST;
        end

        if (clr) begin
            cv_next    = '0;
            sh_next    = '0;
            wh_next    = '0;
            wsi_next   = '0;
            wst_next   = '0;
            empty_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_dur_reg  <= 16'd32;
            pre_reg      <= 16'd32;
            post_reg     <= 16'd80;
            dead_reg     <= 16'd160;
            min_st_reg   <= 5'd8;
            min_hits_reg <= 16'd2000;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_WINDOW_DURATION: win_dur_reg  <= cfg_wdata;
                REG_PRE_DELTA:       pre_reg      <= cfg_wdata;
                REG_POST_DELTA:      post_reg     <= cfg_wdata;
                REG_DEAD_TIME:       dead_reg     <= cfg_wdata;
                REG_MIN_STATIONS:    min_st_reg   <= cfg_wdata[4:0];
                REG_MIN_HITS:        min_hits_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mode_reg  <= MODE_SEARCH;
            wp_reg    <= '0;
            wh_reg    <= '0;
            sh_reg    <= '0;
            wsi_reg   <= '0;
            wst_reg   <= '0;
            empty_reg <= 1'b1;
            hidx_reg  <= '0;
            trig_reg  <= '0;
            evf_reg   <= '0;
            evc_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            cv_reg    <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            wp_reg    <= wp_next;
            wh_reg    <= wh_next;
            sh_reg    <= sh_next;
            wsi_reg   <= wsi_next;
            wst_reg   <= wst_next;
            empty_reg <= empty_next;
            hidx_reg  <= hidx_next;
            trig_reg  <= trig_next;
            evf_reg   <= evf_next;
            evc_reg   <= evc_next;
            pend_reg  <= pend_next;
            cv_reg    <= cv_next;
            mv_reg    <= mv_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        t_reg    <= t_next;
        st_reg   <= st_next;
        last_reg <= last_next;
        i_reg    <= i_next;
        pf_reg   <= pf_next;
        pl_reg   <= pl_next;
        pc_reg   <= pc_next;
        k_reg    <= k_next;
        lbp_reg  <= lbp_next;
        rem_reg  <= rem_next;
        ca_reg   <= ca_next;
        mf_reg   <= mf_next;
        ml_reg   <= ml_next;
        mc_reg   <= mc_next;
    end

`ifndef SYNTHESIS
    // window never grows past the ring capacity
    a_wh_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(wh_reg) <= WIN_CAP)
        else $error("window hit count beyond capacity");

    // every counted station has at least one hit in the window
    a_sh_le_wh: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(sh_reg) <= 32'(wh_reg))
        else $error("more stations than hits in window");

    // search only leaves through a trigger
    a_trig_path: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(mode_reg) == MODE_SEARCH && mode_reg != MODE_SEARCH
        |-> mode_reg == MODE_COLLECT)
        else $error("search left without trigger");

    // a pending event is only parked while the output register is busy
    a_out_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_OUT |-> mv_reg)
        else $error("event parked with free output register");
`endif

endmodule
